### rtl/cesd_pkg.sv
`timescale 1ns / 1ps

package cesd_pkg;

    // character codes
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_7   = 8'h37;
    localparam logic [7:0] CH_NUL = 8'h00;

    // most output words one input word can cause
    localparam int CMD_MAX = 4;
    localparam int CMD_CW  = $clog2(CMD_MAX + 1);
    localparam int CMD_IW  = $clog2(CMD_MAX);

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [CMD_MAX-1:0][7:0] bytes;
        logic [CMD_CW-1:0]       cnt;   // number of valid bytes, 1 to CMD_MAX
        logic                    eos;   // last byte of this command is the terminator
    } t_cmd;

    function automatic logic is_oct(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_7);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h61) && (b <= 8'h66)) ||
               ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    // nibble value of a hex digit, only meaningful when is_hex holds
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        if (b <= 8'h39) begin
            v = b[3:0];
        end else begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [7:0] map_letter(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h61: r = 8'd7;   // a
            8'h62: r = 8'd8;   // b
            8'h66: r = 8'd12;  // f
            8'h6E: r = 8'd10;  // n
            8'h72: r = 8'd13;  // r
            8'h74: r = 8'd9;   // t
            8'h76: r = 8'd11;  // v
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

### rtl/c_escape_sequence_decoder_top.sv
`timescale 1ns / 1ps

// c string escape decoder
// input stream: one raw byte of an escaped string per word, tlast marks the
// final byte of the string. output stream: decoded bytes, one per word; after
// the final input byte a zero terminator word follows with tlast set.
// an input word yields zero to four output words (an escape in progress
// yields none, a broken hex escape plus end of string yields four).
// the front decodes one input word per cycle while the queue has room and
// writes the output bytes it causes as one command into a four-entry queue;
// the back plays each command out one word per cycle while the receiver is
// ready. the first output word of an input word passes through a queue entry
// and then the back's command register. input words are taken one per cycle
// as long as each causes at most one output word and the receiver is ready;
// a word that causes more outputs keeps the output side busy until all are
// out, and the queue absorbs such bursts until it fills. when the receiver
// stalls, the current output word holds, the queue fills and then o_s_tready drops.
// reset (synchronous, active low) empties the queue and the output stage and
// returns the decoder to plain text.
module c_escape_sequence_decoder_top
    import cesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // is_last
    // output stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // end_of_string
);

    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    // accept whenever the queue has room for a command
    assign o_s_tready = q_ready;
    assign accept     = i_s_tvalid && q_ready;

    cesd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    cesd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cesd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_last    (o_m_tlast)
    );

endmodule

### rtl/cesd_front.sv
`timescale 1ns / 1ps

module cesd_front
    import cesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX0  = 3'd2,
        PH_HEX1  = 3'd3,
        PH_OCT   = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_held, n_held;

    t_cmd            cmd;
    logic [CMD_CW-1:0] k;
    logic            replay;
    logic [7:0]      acc_step;
    logic [1:0]      cnt_step;

    assign acc_step = {r_acc[4:0], i_byte[2:0]};
    assign cnt_step = r_cnt + 2'd1;

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_held  = r_held;
        cmd     = '0;
        k       = '0;
        replay  = 1'b0;

        case (r_phase)
            PH_ESC: begin
                if (i_byte == CH_X) begin
                    n_phase = PH_HEX0;
                end else if (is_oct(i_byte)) begin
                    n_acc   = {5'd0, i_byte[2:0]};
                    n_cnt   = 2'd1;
                    n_phase = PH_OCT;
                end else begin
                    cmd.bytes[k[CMD_IW-1:0]] = map_letter(i_byte);
                    k       = k + 1'b1;
                    n_phase = PH_PLAIN;
                end
            end
            PH_HEX0: begin
                if (is_hex(i_byte)) begin
                    n_held  = i_byte;
                    n_phase = PH_HEX1;
                end else begin
                    cmd.bytes[k[CMD_IW-1:0]] = CH_X;
                    k      = k + 1'b1;
                    replay = 1'b1;
                end
            end
            PH_HEX1: begin
                if (is_hex(i_byte)) begin
                    cmd.bytes[k[CMD_IW-1:0]] = {hex_val(r_held), hex_val(i_byte)};
                    k       = k + 1'b1;
                    n_phase = PH_PLAIN;
                end else begin
                    cmd.bytes[k[CMD_IW-1:0]] = CH_X;
                    k      = k + 1'b1;
                    cmd.bytes[k[CMD_IW-1:0]] = r_held;
                    k      = k + 1'b1;
                    replay = 1'b1;
                end
            end
            PH_OCT: begin
                if (is_oct(i_byte)) begin
                    n_acc = acc_step;
                    n_cnt = cnt_step;
                    if (cnt_step == 2'd3) begin
                        cmd.bytes[k[CMD_IW-1:0]] = acc_step;
                        k       = k + 1'b1;
                        n_phase = PH_PLAIN;
                    end
                end else begin
                    cmd.bytes[k[CMD_IW-1:0]] = r_acc;
                    k      = k + 1'b1;
                    replay = 1'b1;
                end
            end
            default: begin
                replay = 1'b1;
            end
        endcase

        // plain text handling, also for a byte that broke off an escape
        if (replay) begin
            if (i_byte == CH_BSL) begin
                n_phase = PH_ESC;
            end else begin
                n_phase = PH_PLAIN;
                cmd.bytes[k[CMD_IW-1:0]] = i_byte;
                k = k + 1'b1;
            end
        end

        // end of string: flush a pending escape, add terminator
        if (i_last) begin
            case (n_phase)
                PH_ESC: begin
                    cmd.bytes[k[CMD_IW-1:0]] = CH_BSL;
                    k = k + 1'b1;
                end
                PH_HEX0: begin
                    cmd.bytes[k[CMD_IW-1:0]] = CH_X;
                    k = k + 1'b1;
                end
                PH_HEX1: begin
                    cmd.bytes[k[CMD_IW-1:0]] = CH_X;
                    k = k + 1'b1;
                    cmd.bytes[k[CMD_IW-1:0]] = n_held;
                    k = k + 1'b1;
                end
                PH_OCT: begin
                    cmd.bytes[k[CMD_IW-1:0]] = n_acc;
                    k = k + 1'b1;
                end
                default: begin
                end
            endcase
            cmd.bytes[k[CMD_IW-1:0]] = CH_NUL;
            k       = k + 1'b1;
            cmd.eos = 1'b1;
            n_phase = PH_PLAIN;
            n_acc   = '0;
            n_cnt   = '0;
            n_held  = '0;
        end

        cmd.cnt = k;
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept && (k != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_held  <= n_held;
        end
    end

endmodule

### rtl/cesd_queue.sv
`timescale 1ns / 1ps

module cesd_queue
    import cesd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/cesd_back.sv
`timescale 1ns / 1ps

module cesd_back
    import cesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_last
);

    t_cmd              r_cur;
    logic              r_busy;
    logic [CMD_IW-1:0] r_idx;

    logic take;
    logic last_byte;
    logic load;

    assign take      = r_busy && i_ready;
    assign last_byte = ({1'b0, r_idx} + 1'b1) == r_cur.cnt;
    assign load      = i_q_valid && (!r_busy || (take && last_byte));

    assign o_q_pop = load;
    assign o_valid = r_busy;
    assign o_data  = r_cur.bytes[r_idx];
    assign o_last  = r_cur.eos && last_byte;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last_byte) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

### rtl/cesd_checker.sv
`timescale 1ns / 1ps

module cesd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // output word holds while stalled
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // terminator word is always zero
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata == 8'h00)
        else $error("terminator word not zero");

    // reset empties the output stage
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // empty queue after reset takes input
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

endmodule

bind c_escape_sequence_decoder_top cesd_checker u_cesd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
